/* rtl/mlpp_pkg.sv */
// Package for the MPLS label push/pop block: constants, codes and shared types.
// No dependencies; the register file, the top level and the testbench import it.
package mlpp_pkg;

  localparam logic [15:0] EtherTypeMpls = 16'h8847;
  localparam logic [7:0]  TtlValue      = 8'hff;
  localparam int          HdrBytesMax   = 22;
  localparam int          HdrBytesBase  = 18;
  localparam int          CntW          = $clog2(HdrBytesMax + 1);

  localparam int MacOffsetEnd   = 5;
  localparam int EtypeOffsetEnd = 13;
  localparam int Label1OffsetEnd = 17;
  localparam int Label2OffsetEnd = 21;

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    RegLocalMac,
    RegPeerMac,
    RegSvcLabelOut,
    RegSvcLabelIn,
    RegTrLabelOut,
    RegTrLabelIn
  } reg_idx_e;

  typedef enum logic {
    ActEncap = 1'b0,
    ActDecap = 1'b1
  } action_e;

  typedef enum logic {
    SideWire   = 1'b0,
    SideTunnel = 1'b1
  } side_e;

  typedef struct packed {
    logic [47:0] local_mac;
    logic [47:0] peer_mac;
    logic [19:0] svc_label_out;
    logic [19:0] svc_label_in;
    logic [19:0] tr_label_out;
    logic [19:0] tr_label_in;
  } cfg_t;

  // Label stack entry: label, EXP 0, bottom-of-stack flag, TTL.
  function automatic logic [31:0] label_word(logic [19:0] label, logic bos);
    return {label, 3'b000, bos, TtlValue};
  endfunction

endpackage

/* rtl/mlpp_if.sv */
// Handshake interfaces of the MPLS label push/pop block: input, result and config channels.
// Depends on nothing; widths follow the fields of each channel.
interface mlpp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       pkt_first;
  logic       pkt_last;

  modport source(output valid, action, data_byte, pkt_first, pkt_last, input ready);
  modport sink(input valid, action, data_byte, pkt_first, pkt_last, output ready);
endinterface

interface mlpp_out_if;
  logic       valid;
  logic       ready;
  logic       side;
  logic [7:0] out_byte;
  logic       out_first;
  logic       out_last;
  logic       run_end;

  modport source(output valid, side, out_byte, out_first, out_last, run_end, input ready);
  modport sink(input valid, side, out_byte, out_first, out_last, run_end, output ready);
endinterface

interface mlpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/mpls_label_push_pop.sv */
// Top level of the MPLS label push/pop block: byte-stream encapsulation and decapsulation.
// Depends on mlpp_pkg, the interfaces in mlpp_if and the register file mlpp_regs.
//
//   channel  | dir | contents
//   in_i     | in  | action, data_byte, pkt_first, pkt_last
//   out_o    | out | side, out_byte, out_first, out_last, run_end
//   cfg_i    | in  | index (0..5), data (48 bits)
//
// An accepted word is held in an input register and its results leave through an
// output register, one result per cycle while the result side does not stall.
// A decapsulated byte or an encapsulated byte without pkt_first gives at most one result,
// so a new word is taken every cycle unless stalled; a first encapsulated byte holds the
// input register until one result per header word and its payload word have gone out.
// Reset clears all control state and the configuration to zero; a stall on the result
// side stops the input register, and the input accepts as soon as its word has gone out.
module mpls_label_push_pop (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlpp_in_if.sink    in_i,
  mlpp_out_if.source out_o,
  mlpp_cfg_if.sink   cfg_i
);
  import mlpp_pkg::*;

  cfg_t cfg;

  mlpp_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register.
  logic       hold_v_q;
  action_e    hold_act_q;
  logic [7:0] hold_byte_q;
  logic       hold_first_q;
  logic       hold_last_q;
  cnt_t       idx_q;

  // Receive-side packet state.
  cnt_t        hc_q, hc_d;
  logic        ok_q, ok_d;
  logic [47:0] sh_q, sh_d;
  logic        ps_q, ps_d;

  // Output register.
  logic       out_v_q;
  side_e      side_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;
  logic       end_q;

  logic                          out_free;
  logic [HdrBytesMax-1:0][7:0]   enc_hdr;
  cnt_t                          enc_hlen;
  cnt_t                          dec_hlen;
  cnt_t                          enc_sel;
  logic                          enc_in_hdr;
  logic                          enc_end;
  logic                          dec_emit;
  logic                          res_valid;
  side_e                         res_side;
  logic [7:0]                    res_byte;
  logic                          res_first;
  logic                          res_last;
  logic                          res_end;
  logic                          step;
  logic                          hold_done;
  logic                          in_ready;
  logic                          in_fire;

  assign out_free = !out_v_q || out_o.ready;

  // Encapsulation: header bytes in wire order, transport word replaced by the
  // service word when no transport label is configured.
  assign enc_hdr = {cfg.peer_mac, cfg.local_mac, EtherTypeMpls,
                    (cfg.tr_label_out != '0) ? label_word(cfg.tr_label_out, 1'b0)
                                             : label_word(cfg.svc_label_out, 1'b1),
                    label_word(cfg.svc_label_out, 1'b1)};
  assign enc_hlen   = (cfg.tr_label_out != '0) ? cnt_t'(HdrBytesMax) : cnt_t'(HdrBytesBase);
  assign enc_in_hdr = hold_first_q && (idx_q < enc_hlen);
  assign enc_sel    = enc_in_hdr ? cnt_t'(HdrBytesMax - 1) - idx_q : '0;
  assign enc_end    = !enc_in_hdr;

  // Decapsulation: header parsing and checks.
  assign dec_hlen = (cfg.tr_label_in != '0) ? cnt_t'(HdrBytesMax) : cnt_t'(HdrBytesBase);

  always_comb begin
    cnt_t        cnt;
    logic        ok;
    logic [47:0] sh;
    logic        ps;
    logic [19:0] want;
    cnt  = hold_first_q ? '0 : hc_q;
    ok   = hold_first_q ? 1'b1 : ok_q;
    sh   = hold_first_q ? '0 : sh_q;
    ps   = hold_first_q ? 1'b0 : ps_q;
    want = (cfg.tr_label_in != '0) ? cfg.tr_label_in : cfg.svc_label_in;
    hc_d     = cnt;
    ok_d     = ok;
    sh_d     = sh;
    ps_d     = ps;
    dec_emit = 1'b0;
    if (ok) begin
      if (cnt < dec_hlen) begin
        sh_d = {sh[39:0], hold_byte_q};
        if (cnt == cnt_t'(MacOffsetEnd)) begin
          ok_d = (sh_d == cfg.local_mac);
        end else if (cnt == cnt_t'(EtypeOffsetEnd)) begin
          ok_d = (sh_d[15:0] == EtherTypeMpls);
        end else if (cnt == cnt_t'(Label1OffsetEnd)) begin
          ok_d = (sh_d[31:12] == want);
        end else if (cnt == cnt_t'(Label2OffsetEnd) && cfg.tr_label_in != '0) begin
          ok_d = (sh_d[31:12] == cfg.svc_label_in);
        end
        hc_d = cnt + cnt_t'(1);
      end else begin
        dec_emit = 1'b1;
        ps_d     = 1'b1;
      end
    end
    if (hold_last_q) begin
      ok_d = 1'b0;
    end
  end

  // Result selection.
  always_comb begin
    if (hold_act_q == ActEncap) begin
      res_valid = hold_v_q;
      res_side  = SideWire;
      res_byte  = enc_in_hdr ? enc_hdr[enc_sel] : hold_byte_q;
      res_first = hold_first_q && (idx_q == '0);
      res_last  = enc_end && hold_last_q;
      res_end   = enc_end;
    end else begin
      res_valid = hold_v_q && dec_emit;
      res_side  = SideTunnel;
      res_byte  = hold_byte_q;
      res_first = !(ps_q && !hold_first_q);
      res_last  = hold_last_q;
      res_end   = 1'b1;
    end
  end

  assign step      = hold_v_q && (out_free || !res_valid);
  assign hold_done = step && (hold_act_q == ActDecap || enc_end);
  assign in_ready  = !hold_v_q || hold_done;
  assign in_fire   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (in_fire) begin
        hold_v_q <= 1'b1;
      end else if (hold_done) begin
        hold_v_q <= 1'b0;
      end
      if (hold_done) begin
        idx_q <= '0;
      end else if (step && hold_act_q == ActEncap) begin
        idx_q <= idx_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_act_q   <= action_e'(in_i.action);
      hold_byte_q  <= in_i.data_byte;
      hold_first_q <= in_i.pkt_first;
      hold_last_q  <= in_i.pkt_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
      ok_q <= 1'b0;
      sh_q <= '0;
      ps_q <= 1'b0;
    end else if (step && hold_act_q == ActDecap) begin
      hc_q <= hc_d;
      ok_q <= ok_d;
      sh_q <= sh_d;
      ps_q <= ps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      side_q  <= res_side;
      byte_q  <= res_byte;
      first_q <= res_first;
      last_q  <= res_last;
      end_q   <= res_end;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.side      = side_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.out_first = first_q;
  assign out_o.out_last  = last_q;
  assign out_o.run_end   = end_q;

  // A header position other than zero only exists for a first encapsulated byte.
  a_idx_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> hold_v_q && hold_act_q == ActEncap && hold_first_q)
    else $error("header position set without a first encapsulated byte");

  // The receive header count never passes the longest header.
  a_hc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= cnt_t'(HdrBytesMax))
    else $error("receive header count out of range");

  // A decapsulated byte is always the only result of its word.
  a_dec_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.side == SideTunnel |-> out_o.run_end)
    else $error("tunnel-side word without run end");

  // The first byte of an encapsulated frame is a header byte, never the last result.
  a_enc_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.side == SideWire && out_o.out_first |-> !out_o.run_end)
    else $error("encapsulated frame start ends its run");

endmodule

/* rtl/mlpp_regs.sv */
// Configuration register file of the MPLS label push/pop block.
// Depends on mlpp_pkg and the mlpp_cfg_if interface.
module mlpp_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  mlpp_cfg_if.sink          cfg_i,
  output mlpp_pkg::cfg_t    cfg_o
);
  import mlpp_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        RegLocalMac:    cfg_q.local_mac     <= cfg_i.data;
        RegPeerMac:     cfg_q.peer_mac      <= cfg_i.data;
        RegSvcLabelOut: cfg_q.svc_label_out <= cfg_i.data[19:0];
        RegSvcLabelIn:  cfg_q.svc_label_in  <= cfg_i.data[19:0];
        RegTrLabelOut:  cfg_q.tr_label_out  <= cfg_i.data[19:0];
        RegTrLabelIn:   cfg_q.tr_label_in   <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

endmodule

/* bench/tb_mpls_label_push_pop.sv */
`timescale 1ns / 1ps
// Testbench for mpls_label_push_pop: directed and random byte streams in both directions,
// every result word checked in order against a predictor of the label push and pop.
// Depends on mlpp_pkg, the channel interfaces of mlpp_if and the block itself.
module tb_mpls_label_push_pop;
  import mlpp_pkg::*;

  localparam int ItemsTarget   = 170;
  localparam int PhaseCount    = 5;
  localparam int DrainCycles   = 30;
  localparam int WatchdogLimit = 2000;
  localparam logic [2:0] RegIdxUnused = 3'd6;

  typedef struct packed {
    side_e      side;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_end;
  } mpls_byte_t;

  class label_stack_scoreboard;
    cfg_t        regs;
    cnt_t        hdr_count;
    logic        hdr_ok;
    logic [47:0] hdr_shift;
    logic        payload_seen;
    mpls_byte_t  expected_bytes[$];
    int          errors;
    int          checked;
    int          to_wire;
    int          to_tunnel;

    function new();
      regs         = '0;
      hdr_count    = '0;
      hdr_ok       = 1'b0;
      hdr_shift    = '0;
      payload_seen = 1'b0;
      errors       = 0;
      checked      = 0;
      to_wire      = 0;
      to_tunnel    = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void write_reg(logic [2:0] index, logic [47:0] data);
      case (index)
        RegLocalMac:    regs.local_mac     = data;
        RegPeerMac:     regs.peer_mac      = data;
        RegSvcLabelOut: regs.svc_label_out = data[19:0];
        RegSvcLabelIn:  regs.svc_label_in  = data[19:0];
        RegTrLabelOut:  regs.tr_label_out  = data[19:0];
        RegTrLabelIn:   regs.tr_label_in   = data[19:0];
        default: ;
      endcase
    endfunction

    function void emit(side_e side, logic [7:0] data, logic first, logic last);
      expected_bytes.push_back('{side, data, first, last, 1'b0});
    endfunction

    function void emit_label(logic [31:0] lse);
      for (int i = 3; i >= 0; i--) emit(SideWire, lse[8*i +: 8], 1'b0, 1'b0);
    endfunction

    function void predict_push(logic [7:0] data, logic first, logic last);
      if (first) begin
        for (int i = 5; i >= 0; i--) emit(SideWire, regs.peer_mac[8*i +: 8], i == 5, 1'b0);
        for (int i = 5; i >= 0; i--) emit(SideWire, regs.local_mac[8*i +: 8], 1'b0, 1'b0);
        emit(SideWire, EtherTypeMpls[15:8], 1'b0, 1'b0);
        emit(SideWire, EtherTypeMpls[7:0], 1'b0, 1'b0);
        if (regs.tr_label_out != '0) emit_label({regs.tr_label_out, 3'b000, 1'b0, TtlValue});
        emit_label({regs.svc_label_out, 3'b000, 1'b1, TtlValue});
      end
      emit(SideWire, data, 1'b0, last);
    endfunction

    function void predict_pop(logic [7:0] data, logic first, logic last);
      int          hdr_len;
      logic [19:0] outer_want;
      hdr_len    = (regs.tr_label_in != '0) ? HdrBytesMax : HdrBytesBase;
      outer_want = (regs.tr_label_in != '0) ? regs.tr_label_in : regs.svc_label_in;
      if (first) begin
        hdr_count    = '0;
        hdr_ok       = 1'b1;
        hdr_shift    = '0;
        payload_seen = 1'b0;
      end
      if (hdr_ok) begin
        if (int'(hdr_count) < hdr_len) begin
          hdr_shift = {hdr_shift[39:0], data};
          case (int'(hdr_count))
            MacOffsetEnd:    hdr_ok = (hdr_shift == regs.local_mac);
            EtypeOffsetEnd:  hdr_ok = (hdr_shift[15:0] == EtherTypeMpls);
            Label1OffsetEnd: hdr_ok = (hdr_shift[31:12] == outer_want);
            Label2OffsetEnd: begin
              if (regs.tr_label_in != '0) hdr_ok = (hdr_shift[31:12] == regs.svc_label_in);
            end
            default: ;
          endcase
          hdr_count++;
        end else begin
          emit(SideTunnel, data, !payload_seen, last);
          payload_seen = 1'b1;
        end
      end
      if (last) hdr_ok = 1'b0;
    endfunction

    function void note_input(action_e act, logic [7:0] data, logic first, logic last);
      int         queued;
      mpls_byte_t tail;
      queued = expected_bytes.size();
      if (act == ActEncap) predict_push(data, first, last);
      else predict_pop(data, first, last);
      if (expected_bytes.size() > queued) begin
        tail         = expected_bytes.pop_back();
        tail.run_end = 1'b1;
        expected_bytes.push_back(tail);
      end
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_output(mpls_byte_t got);
      mpls_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("result word with nothing expected: side %0d, out_byte %02h", got.side, got.data);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      compare("side", want.side, got.side);
      compare("out_byte", want.data, got.data);
      compare("out_first", want.first, got.first);
      compare("out_last", want.last, got.last);
      compare("run_end", want.run_end, got.run_end);
      if (got.side == SideTunnel) to_tunnel++;
      else to_wire++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mlpp_in_if  in_if ();
  mlpp_out_if out_if ();
  mlpp_cfg_if cfg_if ();

  mpls_label_push_pop u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  label_stack_scoreboard sb;
  mpls_byte_t            seen_word;
  int                    stalled_cycles = 0;
  int                    items_sent     = 0;
  bit                    quiet          = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 92) return $urandom_range(4, 9);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic cfg_t make_settings(int phase);
    cfg_t s;
    s.local_mac     = rand48();
    s.peer_mac      = rand48();
    s.svc_label_out = 20'($urandom());
    s.svc_label_in  = 20'($urandom());
    s.tr_label_out  = 20'($urandom_range(1, 20'hfffff));
    s.tr_label_in   = 20'($urandom_range(1, 20'hfffff));
    case (phase)
      1: begin
        s.tr_label_out = '0;
        s.tr_label_in  = '0;
      end
      2: s = '1;
      3: s = '0;
      4: s.tr_label_out = '0;
      default: ;
    endcase
    return s;
  endfunction

  task automatic cfg_write(logic [2:0] index, logic [47:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic apply_settings(cfg_t s);
    cfg_write(RegLocalMac, s.local_mac);
    cfg_write(RegPeerMac, s.peer_mac);
    cfg_write(RegSvcLabelOut, {28'($urandom()), s.svc_label_out});
    cfg_write(RegSvcLabelIn, {28'($urandom()), s.svc_label_in});
    cfg_write(RegTrLabelOut, {28'($urandom()), s.tr_label_out});
    cfg_write(RegTrLabelIn, {28'($urandom()), s.tr_label_in});
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(action_e act, logic [7:0] data, logic first, logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.data_byte <= data;
    in_if.pkt_first <= first;
    in_if.pkt_last  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed frames for the current settings; the rest carry one bad header
  // field, stop early, or lose their pkt_last so the next frame cuts them off.
  task automatic send_decap_packet();
    logic [7:0]  frame[$];
    logic [47:0] dst;
    logic [15:0] etype;
    logic [19:0] outer;
    logic [19:0] inner;
    logic [31:0] lse;
    int          flaw;
    int          n_bytes;
    bit          cut_off;
    flaw  = ($urandom_range(0, 99) < 65) ? 0 : $urandom_range(1, 4);
    dst   = sb.regs.local_mac;
    etype = EtherTypeMpls;
    outer = sb.regs.tr_label_in;
    inner = sb.regs.svc_label_in;
    case (flaw)
      1: dst   ^= 48'(1) << $urandom_range(0, 47);
      2: etype ^= 16'(1) << $urandom_range(0, 15);
      3: outer ^= 20'(1) << $urandom_range(0, 19);
      4: inner ^= 20'(1) << $urandom_range(0, 19);
      default: ;
    endcase
    for (int i = 5; i >= 0; i--) frame.push_back(dst[8*i +: 8]);
    for (int i = 0; i < 6; i++) frame.push_back(8'($urandom()));
    frame.push_back(etype[15:8]);
    frame.push_back(etype[7:0]);
    if (sb.regs.tr_label_in != '0) begin
      lse = {outer, 12'($urandom())};
      for (int i = 3; i >= 0; i--) frame.push_back(lse[8*i +: 8]);
    end
    lse = {inner, 12'($urandom())};
    for (int i = 3; i >= 0; i--) frame.push_back(lse[8*i +: 8]);
    repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom()));
    n_bytes = frame.size();
    if ($urandom_range(0, 9) == 0) n_bytes = $urandom_range(1, n_bytes);
    cut_off = ($urandom_range(0, 6) == 0);
    quiet   = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_word(ActEncap, 8'($urandom()), 1'($urandom_range(0, 3) == 0), 1'($urandom()));
      end
      send_word(ActDecap, frame[i], i == 0, !cut_off && i == n_bytes - 1);
    end
  endtask

  task automatic send_encap_packet();
    int len;
    bit headless;
    len      = $urandom_range(1, 5);
    headless = ($urandom_range(0, 5) == 0);
    quiet    = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      send_word(ActEncap, 8'($urandom()), !headless && i == 0, i == len - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        sb.note_input(action_e'(in_if.action), in_if.data_byte, in_if.pkt_first,
                      in_if.pkt_last);
      end
      if (out_if.valid && out_if.ready) begin
        seen_word = '{side_e'(out_if.side), out_if.out_byte, out_if.out_first,
                      out_if.out_last, out_if.run_end};
        sb.check_output(seen_word);
      end
      if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles >= WatchdogLimit) begin
        $display("tb_mpls_label_push_pop: FAIL");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!quiet) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  initial begin
    int phase_end;
    int roll;
    sb = new();
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.action    <= ActEncap;
    in_if.data_byte <= '0;
    in_if.pkt_first <= 1'b0;
    in_if.pkt_last  <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(RegIdxUnused, rand48());
    apply_settings(make_settings(0));

    // A wire byte before any frame has started is dropped.
    send_word(ActDecap, 8'hff, 1'b0, 1'b1);
    send_word(ActEncap, 8'h00, 1'b1, 1'b0);
    send_word(ActEncap, 8'hff, 1'b0, 1'b1);
    send_word(ActEncap, 8'h5a, 1'b1, 1'b1);
    // Without pkt_first no header is pushed.
    send_word(ActEncap, 8'ha5, 1'b0, 1'b0);
    // A frame that ends inside its header gives nothing, nor does a byte after pkt_last.
    send_word(ActDecap, 8'h00, 1'b1, 1'b0);
    send_word(ActDecap, 8'h12, 1'b0, 1'b0);
    send_word(ActDecap, 8'h34, 1'b0, 1'b1);
    send_word(ActDecap, 8'h56, 1'b0, 1'b0);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        settle();
        apply_settings(make_settings(phase));
      end
      phase_end = ItemsTarget * (phase + 1) / PhaseCount;
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          send_decap_packet();
        end else if (roll < 80) begin
          send_encap_packet();
        end else begin
          quiet = 1'b0;
          send_word(action_e'($urandom_range(0, 1)), 8'($urandom()), 1'($urandom()),
                    1'($urandom()));
        end
      end
    end

    settle();
    $display("Sent %0d input words under %0d register settings; %0d result words checked.",
             items_sent, PhaseCount, sb.checked);
    $display("Of those, %0d bytes went to the wire and %0d to the tunnel.",
             sb.to_wire, sb.to_tunnel);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_mpls_label_push_pop: PASS");
    end else begin
      $display("tb_mpls_label_push_pop: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mlpp_pkg.sv
rtl/mlpp_if.sv
rtl/mlpp_regs.sv
rtl/mpls_label_push_pop.sv
bench/tb_mpls_label_push_pop.sv
